FILE: rtl/pwg_pkg.sv
// Shared constants, types and the quarter-wave sine table of the waveform generator.
// Used by pwg_divider and periodic_waveform_generator_unit; no dependencies.
`default_nettype none

package pwg_pkg;

    // phase and table sizing
    localparam int PHASE_BITS   = 16;
    localparam int SINE_ENTRIES = 1024;
    localparam int LOG2N        = $clog2(SINE_ENTRIES);
    localparam int QTAB_N       = SINE_ENTRIES / 4;
    localparam int QIDX_W       = LOG2N - 2;
    localparam int QV_W         = PHASE_BITS + 1;
    localparam int Y_W          = PHASE_BITS + 2;
    localparam int PROD_W       = 16 + Y_W;

    // item and register widths
    localparam int DATA_W       = 16;
    localparam int SUM_W        = DATA_W + 1;
    localparam int WAVE_W       = 3;
    localparam int CFG_IDX_W    = 3;

    // divider sequencing
    localparam int DIV_STEPS    = SUM_W + PHASE_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // waveform codes
    localparam logic [WAVE_W-1:0] WAVE_SAW     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SINE    = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRI     = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_PULSE   = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_INV_SAW = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD       = 3'd4;

    // register reset values
    localparam logic [DATA_W-1:0] AMPLITUDE_RESET = 16'd256;
    localparam logic [DATA_W-1:0] PERIOD_RESET    = 16'd1000;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // divider result towards the sequencer
    typedef struct packed {
        logic                  done;
        logic [DATA_W-1:0]     modulus;
        logic [PHASE_BITS-1:0] fraction;
    } pwg_div_res_t;

    // sin(pi/2 * 4j / SINE_ENTRIES) scaled by 2^PHASE_BITS, series in Q30, elaboration only
    function automatic logic [QV_W-1:0] qsin_entry(input int unsigned j);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] prod;
        longint      sum;
        longint      v;
        th   = (HALF_PI_Q30 * 64'(4 * j)) / 64'(SINE_ENTRIES);
        th2  = (th * th) >> 30;
        term = th;
        sum  = longint'(th);
        for (int k = 1; k <= 8; k++) begin
            prod = (term * th2) >> 30;
            case (k)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                default: term = prod / 64'd272;
            endcase
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + (longint'(1) << (29 - PHASE_BITS))) >>> (30 - PHASE_BITS);
        return QV_W'(v);
    endfunction

    // first quadrant packed into one constant vector
    function automatic logic [QTAB_N*QV_W-1:0] qsin_build();
        logic [QTAB_N*QV_W-1:0] tab;
        tab = '0;
        for (int j = 0; j < QTAB_N; j++) begin
            tab[j*QV_W +: QV_W] = qsin_entry(j);
        end
        return tab;
    endfunction

    localparam logic [QTAB_N*QV_W-1:0] QSIN_TAB  = qsin_build();
    localparam logic [QV_W-1:0]        QSIN_PEAK = qsin_entry(QTAB_N);

endpackage

`default_nettype wire

FILE: rtl/periodic_waveform_generator_unit.sv
// Periodic waveform generator: time count mod period, phase, wave shape, gain and offset.
// An accepted item passes through the bit-serial divider, which does one compare and subtract
// per cycle, then the shape, multiply and output states; a new item is taken only when idle,
// after the previous result has been loaded into the output register. A zero period skips
// the divider and gives the held result through the output state.
// Reset (aresetn, synchronous): time count and held result cleared, registers to defaults.
// Uses pwg_pkg and pwg_divider.
`default_nettype none

module periodic_waveform_generator_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [pwg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pwg_pkg::DATA_W-1:0]       cfg_wdata,
    // input items
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [pwg_pkg::DATA_W-1:0]       s_delta_time,
    // result items
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [pwg_pkg::DATA_W-1:0]     m_wave_out
);

    localparam int PB  = pwg_pkg::PHASE_BITS;
    localparam int DW  = pwg_pkg::DATA_W;
    localparam int YW  = pwg_pkg::Y_W;
    localparam int PW  = pwg_pkg::PROD_W;
    localparam int SCW = PW - PB + 1;
    localparam int RW  = SCW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SHAPE,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t                            state_reg;
    logic [pwg_pkg::WAVE_W-1:0]        waveform_reg;
    logic signed [DW-1:0]              base_level_reg;
    logic signed [DW-1:0]              amplitude_reg;
    logic [DW-1:0]                     phase_offset_reg;
    logic [DW-1:0]                     period_reg;
    logic [DW-1:0]                     time_count_reg;
    logic signed [DW-1:0]              held_reg;
    logic [PB-1:0]                     frac_reg;
    logic signed [YW-1:0]              y_reg;
    logic signed [PW-1:0]              prod_reg;
    logic                              hold_sel_reg;
    logic                              m_valid_reg;
    logic signed [DW-1:0]              m_wave_out_reg;

    logic                              accept;
    logic                              div_start;
    logic [pwg_pkg::SUM_W-1:0]         div_dividend;
    pwg_pkg::pwg_div_res_t             div_res;

    logic [DW+PB-1:0]                  off_wide;
    logic [PB-1:0]                     phase_x;
    logic [PB+pwg_pkg::LOG2N-1:0]      sidx_wide;
    logic [pwg_pkg::LOG2N-1:0]         sidx;
    logic [1:0]                        quad;
    logic [pwg_pkg::QIDX_W-1:0]        qidx;
    logic [pwg_pkg::QV_W-1:0]          qmag;
    logic signed [YW:0]                twox;
    logic signed [YW:0]                saw_w;
    logic signed [YW:0]                inv_w;
    logic signed [YW-1:0]              sine_y;
    logic signed [YW-1:0]              one_y;
    logic                              low_half;
    logic signed [YW-1:0]              y_next;

    logic signed [PW:0]                rnd;
    logic signed [SCW-1:0]             scaled;
    logic signed [RW-1:0]              res;
    logic                              fits;
    logic signed [DW-1:0]              sat;
    logic signed [DW-1:0]              out_next;
    logic                              out_load;

    // handshake
    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign div_start    = accept && (period_reg != '0);
    assign div_dividend = {1'b0, time_count_reg} + {1'b0, s_delta_time};

    pwg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (period_reg),
        .result   (div_res)
    );

    // phase: fraction plus offset, wrapped
    always_comb begin
        off_wide  = {phase_offset_reg, PB'(0)} >> DW;
        phase_x   = frac_reg + off_wide[PB-1:0];
        low_half  = (phase_x <= PB'(1 << (PB - 1)));
        twox      = $signed({2'b00, phase_x, 1'b0});
        saw_w     = twox - (YW+1)'(1 << PB);
        inv_w     = (YW+1)'(1 << PB) - twox;
        one_y     = YW'(1 << PB);
    end

    // sine lookup from the first-quadrant table
    always_comb begin
        sidx_wide = {phase_x, pwg_pkg::LOG2N'(0)} >> PB;
        sidx      = sidx_wide[pwg_pkg::LOG2N-1:0];
        quad      = sidx[pwg_pkg::LOG2N-1 -: 2];
        qidx      = quad[0] ? (pwg_pkg::QIDX_W'(0) - sidx[pwg_pkg::QIDX_W-1:0])
                            : sidx[pwg_pkg::QIDX_W-1:0];
        if (quad[0] && (sidx[pwg_pkg::QIDX_W-1:0] == '0)) begin
            qmag = pwg_pkg::QSIN_PEAK;
        end else begin
            qmag = pwg_pkg::QSIN_TAB[qidx*pwg_pkg::QV_W +: pwg_pkg::QV_W];
        end
        sine_y = quad[1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end

    // wave shape select
    always_comb begin
        case (waveform_reg)
            pwg_pkg::WAVE_SINE:    y_next = sine_y;
            pwg_pkg::WAVE_TRI:     y_next = low_half ? saw_w[YW-1:0] : inv_w[YW-1:0];
            pwg_pkg::WAVE_PULSE:   y_next = low_half ? one_y : -one_y;
            pwg_pkg::WAVE_INV_SAW: y_next = inv_w[YW-1:0];
            default:               y_next = saw_w[YW-1:0];
        endcase
    end

    // round half up, add base, saturate to Q8.8
    always_comb begin
        rnd      = (PW+1)'(prod_reg) + (PW+1)'(1 << (PB - 1));
        scaled   = rnd[PW:PB];
        res      = RW'(scaled) + RW'(base_level_reg);
        fits     = (&res[RW-1:DW-1]) || !(|res[RW-1:DW-1]);
        if (fits) begin
            sat = res[DW-1:0];
        end else if (res[RW-1]) begin
            sat = {1'b1, (DW-1)'(0)};
        end else begin
            sat = {1'b0, {(DW-1){1'b1}}};
        end
        out_next = hold_sel_reg ? held_reg : sat;
        out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    // sequencer, registers and output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            hold_sel_reg     <= 1'b0;
            waveform_reg     <= pwg_pkg::WAVE_SAW;
            base_level_reg   <= '0;
            amplitude_reg    <= pwg_pkg::AMPLITUDE_RESET;
            phase_offset_reg <= '0;
            period_reg       <= pwg_pkg::PERIOD_RESET;
            time_count_reg   <= '0;
            held_reg         <= '0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    pwg_pkg::REG_WAVEFORM:     waveform_reg     <= cfg_wdata[pwg_pkg::WAVE_W-1:0];
                    pwg_pkg::REG_BASE_LEVEL:   base_level_reg   <= cfg_wdata;
                    pwg_pkg::REG_AMPLITUDE:    amplitude_reg    <= cfg_wdata;
                    pwg_pkg::REG_PHASE_OFFSET: phase_offset_reg <= cfg_wdata;
                    pwg_pkg::REG_PERIOD:       period_reg       <= cfg_wdata;
                    default: ;
                endcase
            end

            // output register
            if (out_load) begin
                m_valid_reg    <= 1'b1;
                m_wave_out_reg <= out_next;
                held_reg       <= out_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        hold_sel_reg <= (period_reg == '0);
                        state_reg    <= (period_reg == '0) ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        time_count_reg <= div_res.modulus;
                        frac_reg       <= div_res.fraction;
                        state_reg      <= ST_SHAPE;
                    end
                end
                ST_SHAPE: begin
                    y_reg     <= y_next;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= PW'(amplitude_reg) * PW'(y_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_wave_out = m_wave_out_reg;

endmodule

`default_nettype wire

FILE: rtl/pwg_divider.sv
// Bit-serial restoring divider: one compare and subtract per cycle.
// Gives (dividend mod divisor) and the fraction bits of the quotient; uses pwg_pkg.
`default_nettype none

module pwg_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pwg_pkg::SUM_W-1:0]     dividend,
    input  wire logic [pwg_pkg::DATA_W-1:0]    divisor,
    output pwg_pkg::pwg_div_res_t              result
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [pwg_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [pwg_pkg::SUM_W-1:0]         src_reg;
    logic [pwg_pkg::DATA_W-1:0]        rem_reg;
    logic [pwg_pkg::DATA_W-1:0]        mod_reg;
    logic [pwg_pkg::PHASE_BITS-1:0]    quo_reg;

    logic [pwg_pkg::DATA_W:0]          trial;
    logic [pwg_pkg::DATA_W+1:0]        diff;
    logic                              ge;
    logic [pwg_pkg::DATA_W-1:0]        rem_next;
    logic [pwg_pkg::PHASE_BITS-1:0]    quo_next;

    // shared compare and subtract
    always_comb begin
        trial    = {rem_reg, src_reg[pwg_pkg::SUM_W-1]};
        diff     = {1'b0, trial} - {2'b00, divisor};
        ge       = ~diff[pwg_pkg::DATA_W+1];
        rem_next = ge ? diff[pwg_pkg::DATA_W-1:0] : trial[pwg_pkg::DATA_W-1:0];
        quo_next = {quo_reg[pwg_pkg::PHASE_BITS-2:0], ge};
    end

    // step sequencing: integer part first, then the fraction bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                src_reg  <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                src_reg <= {src_reg[pwg_pkg::SUM_W-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pwg_pkg::DIV_CNT_W'(pwg_pkg::SUM_W - 1)) begin
                    mod_reg <= rem_next;
                end
                if (cnt_reg == pwg_pkg::DIV_CNT_W'(pwg_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign result.done     = done_reg;
    assign result.modulus  = mod_reg;
    assign result.fraction = quo_reg;

endmodule

`default_nettype wire
